// ----- rtl/cci_pkg.sv -----
package cci_pkg;

	typedef enum logic [1:0] {
		ST_INTERSECT  = 2'd0,
		ST_FAR        = 2'd1,
		ST_INSIDE     = 2'd2,
		ST_COINCIDENT = 2'd3
	} status_t;

	// slice width of the multiplier operand that is split into partial products
	localparam int CHUNK = 16;

endpackage

// ----- rtl/cci_queue.sv -----
module cci_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  store_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

// ----- rtl/cci_front.sv -----
module cci_front import cci_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [COORD_BITS-1:0] center_a_x,
	input  logic signed [COORD_BITS-1:0] center_a_y,
	input  logic        [COORD_BITS-2:0] radius_a,
	input  logic signed [COORD_BITS-1:0] center_b_x,
	input  logic signed [COORD_BITS-1:0] center_b_y,
	input  logic        [COORD_BITS-2:0] radius_b,
	input  logic                         q_full,
	output logic                         q_push,
	output logic [12*COORD_BITS+8:0]     rec
);

	localparam int C    = COORD_BITS;
	localparam int D2W  = 2*C + 2;
	localparam int KW   = 2*C + 1;
	localparam int RECW = 12*C + 9;

	logic signed [C:0] dx, dy;
	logic [C:0]        mx, my;
	logic [C-1:0]      rsum;
	logic [C-2:0]      rdiff;
	logic              en;

	logic [C-1:0]      ax_s1, ay_s1;
	logic              dxn_s1, dyn_s1;
	logic [C:0]        mx_s1, my_s1;
	logic [D2W-1:0]    mx2_s1, my2_s1;
	logic [2*C-1:0]    sum2_s1;
	logic [2*C-3:0]    dif2_s1, ra2_s1, rb2_s1;
	logic              v_s1, v_s2;
	logic [RECW-1:0]   rec_s2;

	logic [D2W-1:0]    d2;
	logic [D2W:0]      pk, rb2x, kmag;
	logic              kn;
	logic [D2W-1:0]    a_full, b_full;
	status_t           st;

	assign en     = !v_s2 || !q_full;
	assign full   = !en;
	assign q_push = v_s2 && !q_full;
	assign rec    = rec_s2;

	assign dx    = {center_b_x[C-1], center_b_x} - {center_a_x[C-1], center_a_x};
	assign dy    = {center_b_y[C-1], center_b_y} - {center_a_y[C-1], center_a_y};
	assign mx    = dx[C] ? $unsigned(-dx) : $unsigned(dx);
	assign my    = dy[C] ? $unsigned(-dy) : $unsigned(dy);
	assign rsum  = {1'b0, radius_a} + {1'b0, radius_b};
	assign rdiff = (radius_a >= radius_b) ? radius_a - radius_b : radius_b - radius_a;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= center_a_x;
			ay_s1   <= center_a_y;
			dxn_s1  <= dx[C];
			dyn_s1  <= dy[C];
			mx_s1   <= mx;
			my_s1   <= my;
			mx2_s1  <= D2W'(mx) * D2W'(mx);
			my2_s1  <= D2W'(my) * D2W'(my);
			sum2_s1 <= (2*C)'(rsum) * (2*C)'(rsum);
			dif2_s1 <= (2*C-2)'(rdiff) * (2*C-2)'(rdiff);
			ra2_s1  <= (2*C-2)'(radius_a) * (2*C-2)'(radius_a);
			rb2_s1  <= (2*C-2)'(radius_b) * (2*C-2)'(radius_b);
		end
	end

	always_comb begin
		d2     = mx2_s1 + my2_s1;
		pk     = (D2W+1)'(ra2_s1) + (D2W+1)'(d2);
		rb2x   = (D2W+1)'(rb2_s1);
		kn     = pk < rb2x;
		kmag   = kn ? rb2x - pk : pk - rb2x;
		a_full = D2W'(sum2_s1) - d2;
		b_full = d2 - D2W'(dif2_s1);
		priority if (d2 == '0) begin
			st = ST_COINCIDENT;
		end else if (d2 > D2W'(sum2_s1)) begin
			st = ST_FAR;
		end else if (d2 < D2W'(dif2_s1)) begin
			st = ST_INSIDE;
		end else begin
			st = ST_INTERSECT;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rec_s2 <= {st, ax_s1, ay_s1, dxn_s1, dyn_s1, kn, mx_s1, my_s1, kmag[KW-1:0],
				a_full[2*C-1:0], b_full[2*C-1:0], d2[2*C-1:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
		end
	end

endmodule

// ----- rtl/cci_delay.sv -----
module cci_delay #(
	parameter int W = 8,
	parameter int L = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] pipe_s [L];

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= d;
			for (int i = 1; i < L; i++) begin
				pipe_s[i] <= pipe_s[i-1];
			end
		end
	end

	assign q = pipe_s[L-1];

endmodule

// ----- rtl/cci_mul.sv -----
module cci_mul import cci_pkg::*; #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic               clk,
	input  logic               en,
	input  logic [AW-1:0]      a,
	input  logic [BW-1:0]      b,
	output logic [AW+BW-1:0]   prod
);

	localparam int NCH = (BW + CHUNK - 1) / CHUNK;
	localparam int BXW = NCH * CHUNK;
	localparam int PPW = AW + CHUNK;
	localparam int PW  = AW + BW;

	logic [BXW-1:0] b_ext;
	logic [PPW-1:0] pp_s1 [NCH];
	logic [PW-1:0]  acc;
	logic [PW-1:0]  prod_s2;

	assign b_ext = BXW'(b);

	// one partial product per slice of b, summed in the next stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NCH; j++) begin
				pp_s1[j] <= PPW'(a) * PPW'(b_ext[j*CHUNK +: CHUNK]);
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int j = 0; j < NCH; j++) begin
			acc = acc + (PW'(pp_s1[j]) << (j*CHUNK));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= acc;
		end
	end

	assign prod = prod_s2;

endmodule

// ----- rtl/cci_sqrt.sv -----
module cci_sqrt #(
	parameter int QW = 96
) (
	input  logic            clk,
	input  logic            en,
	input  logic [QW-1:0]   arg,
	output logic [QW/2:0]   root
);

	localparam int RW = QW / 2;

	logic [RW-1:0] root_s [RW+1];
	logic [RW:0]   rem_s  [RW+1];
	logic [QW-1:0] arg_s  [RW+1];
	logic [RW-1:0] root_n [RW+1];
	logic [RW:0]   rem_n  [RW+1];
	logic [QW-1:0] arg_n  [RW+1];
	logic [RW:0]   out_s;

	// one root bit per stage, two argument bits brought down each time
	always_comb begin
		logic [RW+2:0] cur, trial, diff;
		logic          ge;
		root_n[0] = '0;
		rem_n[0]  = '0;
		arg_n[0]  = arg;
		for (int i = 1; i <= RW; i++) begin
			cur       = {rem_s[i-1], arg_s[i-1][QW-1:QW-2]};
			trial     = {1'b0, root_s[i-1], 2'b01};
			ge        = cur >= trial;
			diff      = cur - trial;
			rem_n[i]  = ge ? diff[RW:0] : cur[RW:0];
			root_n[i] = {root_s[i-1][RW-2:0], ge};
			arg_n[i]  = arg_s[i-1] << 2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i <= RW; i++) begin
				root_s[i] <= root_n[i];
				rem_s[i]  <= rem_n[i];
				arg_s[i]  <= arg_n[i];
			end
			// round to nearest: step up when the remainder exceeds the root
			out_s <= (RW+1)'(root_s[RW])
				+ (RW+1)'(rem_s[RW] > (RW+1)'(root_s[RW]));
		end
	end

	assign root = out_s;

endmodule

// ----- rtl/cci_div.sv -----
module cci_div #(
	parameter int NW = 75,
	parameter int DW = 49,
	parameter int OW = 26
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic          neg,
	input  logic [DW-1:0] den,
	output logic [OW-1:0] quo
);

	logic [DW-1:0] rem_s [NW+1];
	logic [OW-1:0] quo_s [NW+1];
	logic [NW-1:0] num_s [NW+1];
	logic          neg_s [NW+1];
	logic [DW-1:0] den_s [NW+1];
	logic [DW-1:0] rem_n [NW+1];
	logic [OW-1:0] quo_n [NW+1];
	logic [NW-1:0] num_n [NW+1];
	logic [OW-1:0] mag;
	logic          inc;
	logic [OW-1:0] res_s;

	// restoring division, one quotient bit per stage; only the low bits are kept
	always_comb begin
		logic [DW:0] cur, dext, diff;
		logic        ge;
		rem_n[0] = '0;
		quo_n[0] = '0;
		num_n[0] = num;
		for (int i = 1; i <= NW; i++) begin
			cur      = {rem_s[i-1], num_s[i-1][NW-1]};
			dext     = {1'b0, den_s[i-1]};
			ge       = cur >= dext;
			diff     = cur - dext;
			rem_n[i] = ge ? diff[DW-1:0] : cur[DW-1:0];
			quo_n[i] = {quo_s[i-1][OW-2:0], ge};
			num_n[i] = num_s[i-1] << 1;
		end
	end

	// ties go away from zero: round up when twice the remainder reaches the divisor
	assign inc = {rem_s[NW], 1'b0} >= {1'b0, den_s[NW]};
	assign mag = quo_s[NW] + OW'(inc);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= neg;
			den_s[0] <= den;
			for (int i = 1; i <= NW; i++) begin
				neg_s[i] <= neg_s[i-1];
				den_s[i] <= den_s[i-1];
			end
			for (int i = 0; i <= NW; i++) begin
				rem_s[i] <= rem_n[i];
				quo_s[i] <= quo_n[i];
				num_s[i] <= num_n[i];
			end
			res_s <= neg_s[NW] ? -mag : mag;
		end
	end

	assign quo = res_s;

endmodule

// ----- rtl/cci_back.sv -----
module cci_back import cci_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	output logic                       q_pop,
	input  logic [12*COORD_BITS+8:0]   rec,
	input  logic                       pop,
	output logic                       empty,
	output logic [1:0]                 status,
	output logic [COORD_BITS+1:0]      point_one_x,
	output logic [COORD_BITS+1:0]      point_one_y,
	output logic [COORD_BITS+1:0]      point_two_x,
	output logic [COORD_BITS+1:0]      point_two_y
);

	localparam int C    = COORD_BITS;
	localparam int RECW = 12*C + 9;
	localparam int KW   = 2*C + 1;
	localparam int SW   = 2*C + 1;
	localparam int QW   = 4*C;
	localparam int PW   = 3*C + 2;
	localparam int NW   = 3*C + 3;
	localparam int DW   = 2*C + 1;
	localparam int OW   = C + 2;
	localparam int LS   = 2*C + 2;
	localparam int LD   = NW + 2;
	localparam int WA   = 8*C + 9;
	localparam int WB   = 4*C + 6;
	localparam int WC   = 2*C + 2;
	localparam int LAT  = 2 + LS + 2 + 1 + LD;

	logic            en;
	logic [RECW-1:0] rec_s0;
	logic            v_s0;
	logic            vld_s [LAT];

	logic [1:0]      st0;
	logic [C-1:0]    ax0, ay0;
	logic            dxn0, dyn0, kn0;
	logic [C:0]      mx0, my0;
	logic [KW-1:0]   km0;
	logic [2*C-1:0]  a0, b0;
	logic [DW-1:0]   den0;

	logic [QW-1:0]   qprod;
	logic [SW-1:0]   sroot;

	logic [1:0]      st_r;
	logic [C-1:0]    ax_r, ay_r;
	logic            dxn_r, dyn_r, kn_r;
	logic [C:0]      mx_r, my_r;
	logic [KW-1:0]   km_r;
	logic [DW-1:0]   den_r;

	logic [PW-1:0]   pkx, pky, psx, psy;
	logic [1:0]      st_p;
	logic [C-1:0]    ax_p, ay_p;
	logic            dxn_p, dyn_p, kn_p;
	logic [DW-1:0]   den_p;

	logic [NW:0]     sv [4];
	logic [NW-1:0]   num_s1 [4];
	logic            neg_s1 [4];
	logic [DW-1:0]   den_s1;
	logic [1:0]      st_s1;
	logic [C-1:0]    ax_s1, ay_s1;

	logic [OW-1:0]   off [4];
	logic [1:0]      st_d;
	logic [C-1:0]    ax_d, ay_d;
	logic [OW-1:0]   base_x, base_y;

	logic            v_s2;
	logic [1:0]      status_s2;
	logic [OW-1:0]   pt_s2 [4];

	function automatic logic [NW:0] signed_sum(input logic n1, input logic [PW-1:0] p1,
		input logic n2, input logic [PW-1:0] p2);
		logic [NW:0] t1, t2;
		t1 = n1 ? -(NW+1)'(p1) : (NW+1)'(p1);
		t2 = n2 ? -(NW+1)'(p2) : (NW+1)'(p2);
		return t1 + t2;
	endfunction

	// the whole back end advances together unless the output register is held
	assign en    = !v_s2 || pop;
	assign q_pop = en && !q_empty;

	always_ff @(posedge clk) begin
		if (en) begin
			rec_s0 <= rec;
		end
	end

	assign {st0, ax0, ay0, dxn0, dyn0, kn0, mx0, my0, km0, a0, b0, den0} = rec_s0;

	cci_mul #(.AW(2*C), .BW(2*C)) u_mul_q (
		.clk(clk), .en(en), .a(a0), .b(b0), .prod(qprod)
	);

	cci_sqrt #(.QW(QW)) u_sqrt (
		.clk(clk), .en(en), .arg(qprod), .root(sroot)
	);

	cci_delay #(.W(WA), .L(2 + LS)) u_dly_a (
		.clk(clk), .en(en),
		.d({ax0, ay0, dxn0, dyn0, kn0, mx0, my0, km0, den0, st0}),
		.q({ax_r, ay_r, dxn_r, dyn_r, kn_r, mx_r, my_r, km_r, den_r, st_r})
	);

	cci_mul #(.AW(KW), .BW(C + 1)) u_mul_kx (
		.clk(clk), .en(en), .a(km_r), .b(mx_r), .prod(pkx)
	);
	cci_mul #(.AW(KW), .BW(C + 1)) u_mul_ky (
		.clk(clk), .en(en), .a(km_r), .b(my_r), .prod(pky)
	);
	cci_mul #(.AW(SW), .BW(C + 1)) u_mul_sx (
		.clk(clk), .en(en), .a(sroot), .b(mx_r), .prod(psx)
	);
	cci_mul #(.AW(SW), .BW(C + 1)) u_mul_sy (
		.clk(clk), .en(en), .a(sroot), .b(my_r), .prod(psy)
	);

	cci_delay #(.W(WB), .L(2)) u_dly_b (
		.clk(clk), .en(en),
		.d({ax_r, ay_r, dxn_r, dyn_r, kn_r, den_r, st_r}),
		.q({ax_p, ay_p, dxn_p, dyn_p, kn_p, den_p, st_p})
	);

	// numerators of both points, summed from sign-and-magnitude products
	always_comb begin
		sv[0] = signed_sum(kn_p ^ dxn_p, pkx, !dyn_p, psy);
		sv[1] = signed_sum(kn_p ^ dyn_p, pky, dxn_p, psx);
		sv[2] = signed_sum(kn_p ^ dxn_p, pkx, dyn_p, psy);
		sv[3] = signed_sum(kn_p ^ dyn_p, pky, !dxn_p, psx);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				neg_s1[i] <= sv[i][NW];
				num_s1[i] <= sv[i][NW] ? NW'(-sv[i]) : NW'(sv[i]);
			end
			den_s1 <= den_p;
			st_s1  <= st_p;
			ax_s1  <= ax_p;
			ay_s1  <= ay_p;
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_div
		cci_div #(.NW(NW), .DW(DW), .OW(OW)) u_div (
			.clk(clk), .en(en), .num(num_s1[g]), .neg(neg_s1[g]), .den(den_s1),
			.quo(off[g])
		);
	end

	cci_delay #(.W(WC), .L(LD)) u_dly_c (
		.clk(clk), .en(en),
		.d({ax_s1, ay_s1, st_s1}),
		.q({ax_d, ay_d, st_d})
	);

	assign base_x = {{2{ax_d[C-1]}}, ax_d};
	assign base_y = {{2{ay_d[C-1]}}, ay_d};

	always_ff @(posedge clk) begin
		if (en) begin
			status_s2 <= st_d;
			if (st_d == ST_INTERSECT) begin
				pt_s2[0] <= base_x + off[0];
				pt_s2[1] <= base_y + off[1];
				pt_s2[2] <= base_x + off[2];
				pt_s2[3] <= base_y + off[3];
			end else begin
				for (int i = 0; i < 4; i++) begin
					pt_s2[i] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s2 <= 1'b0;
			for (int i = 0; i < LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s0     <= !q_empty;
			vld_s[0] <= v_s0;
			for (int i = 1; i < LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			v_s2 <= vld_s[LAT-1];
		end
	end

	assign empty       = !v_s2;
	assign status      = status_s2;
	assign point_one_x = pt_s2[0];
	assign point_one_y = pt_s2[1];
	assign point_two_x = pt_s2[2];
	assign point_two_y = pt_s2[3];

endmodule

// ----- rtl/circle_circle_intersection.sv -----
// Circle-circle intersection: two circles in signed fixed point come in, one status and
// two intersection points go out per transaction, one transaction per cycle when nothing stalls.
// The square root produces one root bit per stage over 2*COORD_BITS stages, and the four
// dividers one quotient bit per stage over 3*COORD_BITS+3 stages. A front end classifies
// the pair and a four-entry queue decouples it from the arithmetic back end, so each side
// stalls on its own. Point one lies on the left of the line from centre A to centre B;
// point fields are zero unless status is 0.
module circle_circle_intersection #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [COORD_BITS-1:0] center_a_x,
	input  logic signed [COORD_BITS-1:0] center_a_y,
	input  logic        [COORD_BITS-2:0] radius_a,
	input  logic signed [COORD_BITS-1:0] center_b_x,
	input  logic signed [COORD_BITS-1:0] center_b_y,
	input  logic        [COORD_BITS-2:0] radius_b,
	output logic                         empty,
	input  logic                         pop,
	output logic        [1:0]            status,
	output logic signed [COORD_BITS+1:0] point_one_x,
	output logic signed [COORD_BITS+1:0] point_one_y,
	output logic signed [COORD_BITS+1:0] point_two_x,
	output logic signed [COORD_BITS+1:0] point_two_y
);

	localparam int RECW = 12*COORD_BITS + 9;

	logic            f_push, q_full, q_empty, q_pop;
	logic [RECW-1:0] f_rec, q_rec;

	cci_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.center_a_x(center_a_x), .center_a_y(center_a_y), .radius_a(radius_a),
		.center_b_x(center_b_x), .center_b_y(center_b_y), .radius_b(radius_b),
		.q_full(q_full), .q_push(f_push), .rec(f_rec)
	);

	cci_queue #(.W(RECW), .DEPTH(4)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(f_push), .din(f_rec), .full(q_full),
		.pop(q_pop), .dout(q_rec), .empty(q_empty)
	);

	cci_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_pop(q_pop), .rec(q_rec),
		.pop(pop), .empty(empty), .status(status),
		.point_one_x(point_one_x), .point_one_y(point_one_y),
		.point_two_x(point_two_x), .point_two_y(point_two_y)
	);

endmodule

// ----- rtl/cci_checker.sv -----
module cci_checker import cci_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         push,
	input logic                         full,
	input logic                         empty,
	input logic                         pop,
	input logic        [1:0]            status,
	input logic signed [COORD_BITS+1:0] point_one_x,
	input logic signed [COORD_BITS+1:0] point_one_y,
	input logic signed [COORD_BITS+1:0] point_two_x,
	input logic signed [COORD_BITS+1:0] point_two_y
);

	logic [15:0] outstanding_q;
	logic        in_acc, out_acc;

	assign in_acc  = push && !full;
	assign out_acc = pop && !empty;

	// count transactions taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + 16'(in_acc) - 16'(out_acc);
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> outstanding_q != '0)
		else $error("result shown with no transaction outstanding");

	a_zero_points: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_INTERSECT) |->
			(point_one_x == '0 && point_one_y == '0 && point_two_x == '0 && point_two_y == '0))
		else $error("points not cleared for a non-intersecting pair");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status) && $stable(point_one_x)
			&& $stable(point_one_y) && $stable(point_two_x) && $stable(point_two_y)))
		else $error("waiting result changed before it was taken");

endmodule

bind circle_circle_intersection cci_checker #(.COORD_BITS(COORD_BITS)) u_cci_checker (.*);

// ----- dv/circle_circle_intersection_test.sv -----
module circle_circle_intersection_test;
	import cci_pkg::*;

	localparam int CB = 24;
	localparam int RB = CB - 1;
	localparam int OB = CB + 2;
	localparam int LATENCY = 5 * CB + 17;

	typedef struct {
		status_t              st;
		logic signed [OB-1:0] p1x, p1y, p2x, p2y;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic signed [CB-1:0] center_a_x = '0, center_a_y = '0, center_b_x = '0, center_b_y = '0;
	logic [RB-1:0] radius_a = '0, radius_b = '0;
	logic [1:0] status;
	logic signed [OB-1:0] point_one_x, point_one_y, point_two_x, point_two_y;

	crossing_t pending[$];
	int n_errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_meet = 0, n_far = 0, n_inside = 0, n_coinc = 0;
	bit calm = 1'b0;

	circle_circle_intersection #(.COORD_BITS(CB)) i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#50000000;
		$display("Verification failed");
		$finish;
	end

	// integer square root rounded to nearest: step up when the remainder exceeds the root
	function automatic logic [127:0] root_rounded(input logic [127:0] q);
		logic [127:0] res, cand;
		res = '0;
		for (int i = 63; i >= 0; i--) begin
			cand = res | (128'd1 << i);
			if (cand * cand <= q)
				res = cand;
		end
		if (q - res * res > res)
			res = res + 1;
		return res;
	endfunction

	// quotient rounded to nearest, ties away from zero
	function automatic logic signed [OB-1:0] offset_rounded(input logic signed [159:0] n,
			input logic [127:0] d);
		logic [159:0] mag, quo, rem;
		mag = n < 0 ? -n : n;
		quo = mag / d;
		rem = mag % d;
		if (rem >= d - rem)
			quo = quo + 1;
		return n < 0 ? -quo[OB-1:0] : quo[OB-1:0];
	endfunction

	function automatic crossing_t crossing_of(input logic signed [CB-1:0] ax, ay, bx, by,
			input logic [RB-1:0] ra, rb);
		crossing_t c;
		logic signed [159:0] dx, dy, d2, sum2, dif2, k, s;
		logic [127:0] q;
		c = '{ST_INTERSECT, '0, '0, '0, '0};
		dx = bx - ax;
		dy = by - ay;
		d2 = dx * dx + dy * dy;
		sum2 = (ra + rb) * (ra + rb);
		dif2 = (ra - rb) * (ra - rb);
		if (d2 == 0) begin
			c.st = ST_COINCIDENT;
			return c;
		end
		if (d2 > sum2) begin
			c.st = ST_FAR;
			return c;
		end
		if (d2 < dif2) begin
			c.st = ST_INSIDE;
			return c;
		end
		k = ra * ra - rb * rb + d2;
		q = (sum2 - d2) * (d2 - dif2);
		s = root_rounded(q);
		c.p1x = ax + offset_rounded(dx * k - dy * s, 2 * d2);
		c.p1y = ay + offset_rounded(dy * k + dx * s, 2 * d2);
		c.p2x = ax + offset_rounded(dx * k + dy * s, 2 * d2);
		c.p2y = ay + offset_rounded(dy * k - dx * s, 2 * d2);
		return c;
	endfunction

	task automatic send_circles(input logic signed [CB-1:0] ax, ay, bx, by,
			input logic [RB-1:0] ra, rb);
		crossing_t c;
		while (!calm && $urandom_range(99) < 27) begin
			push <= 1'b0;
			@(negedge clk);
		end
		center_a_x <= ax;
		center_a_y <= ay;
		radius_a <= ra;
		center_b_x <= bx;
		center_b_y <= by;
		radius_b <= rb;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		c = crossing_of(ax, ay, bx, by, ra, rb);
		pending.insert(pending.size(), c);
		case (c.st)
			ST_INTERSECT: n_meet++;
			ST_FAR: n_far++;
			ST_INSIDE: n_inside++;
			default: n_coinc++;
		endcase
		n_sent++;
		@(negedge clk);
	endtask

	// result side: randomly stall, check on each accepted transaction
	always @(negedge clk)
		pop <= calm || ($urandom_range(99) >= 27);

	always @(posedge clk) begin
		crossing_t e;
		if (arst_n && pop && !empty) begin
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status=%0d", $time, status);
				n_errors++;
			end else begin
				e = pending.pop_front();
				n_checked++;
				if (status !== e.st || point_one_x !== e.p1x || point_one_y !== e.p1y
						|| point_two_x !== e.p2x || point_two_y !== e.p2y) begin
					$display("%0t: mismatch expected st=%0d p1=(%0d,%0d) p2=(%0d,%0d)",
						$time, e.st, e.p1x, e.p1y, e.p2x, e.p2y);
					$display("%0t:          actual   st=%0d p1=(%0d,%0d) p2=(%0d,%0d)",
						$time, status, point_one_x, point_one_y, point_two_x, point_two_y);
					n_errors++;
				end
			end
		end
	end

	task automatic test_extremes();
		logic signed [CB-1:0] mn, mx;
		logic [RB-1:0] rmax;
		mn = {1'b1, {(CB-1){1'b0}}};
		mx = {1'b0, {(CB-1){1'b1}}};
		rmax = '1;
		send_circles(0, 0, 0, 0, 0, 0);
		send_circles(100, -50, 100, -50, 300, 7);
		send_circles(mn, mn, mx, mx, rmax, rmax);
		send_circles(mx, mn, mn, mx, rmax, rmax);
		send_circles(mn, mn, mx, mx, 0, 0);
		send_circles(0, 0, 2560, 0, 1280, 1280);
		send_circles(0, 0, 0, 2560, 1536, 1024);
		send_circles(0, 0, 256, 0, 2560, 256);
		send_circles(0, 0, 256, 0, 256, 2560);
		send_circles(0, 0, 768, 1024, 1024, 768);
		send_circles(-768, 512, 768, -512, 1000, 1000);
		send_circles(0, 0, 1, 1, 0, 1);
		send_circles(0, 0, mx, 0, rmax, 1);
		send_circles(mn, 0, mn + 1, 0, rmax, rmax);
		send_circles(5, 5, 5, 5, rmax, 0);
		send_circles(0, 0, 300, 0, 100, 200);
		send_circles(0, 0, 300, 0, 200, 100);
	endtask

	task automatic test_random(input int count);
		logic signed [CB-1:0] ax, ay, bx, by;
		logic [RB-1:0] ra, rb;
		int dist2, mode;
		for (int i = 0; i < count; i++) begin
			calm = (i >= count / 3 && i < count / 2);
			mode = $urandom_range(9);
			ax = CB'($urandom);
			ay = CB'($urandom);
			if (mode < 6) begin
				// nearby circles with radii around the spacing, so most pairs meet
				dist2 = $urandom_range(1 << $urandom_range(4, 22));
				bx = CB'(ax + $signed($urandom_range(2 * dist2)) - dist2);
				by = CB'(ay + $signed($urandom_range(2 * dist2)) - dist2);
				ra = RB'($urandom_range(2 * dist2));
				rb = RB'($urandom_range(2 * dist2));
			end else if (mode < 9) begin
				bx = CB'($urandom);
				by = CB'($urandom);
				ra = RB'($urandom);
				rb = RB'($urandom);
			end else begin
				bx = ax;
				by = ay;
				ra = RB'($urandom);
				rb = RB'($urandom);
			end
			send_circles(ax, ay, bx, by, ra, rb);
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_extremes();
		test_random(1100);
		push <= 1'b0;
		while (pending.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);
		$display("Sent %0d circle pairs, checked %0d results", n_sent, n_checked);
		$display("Meeting %0d, apart %0d, nested %0d, concentric %0d",
			n_meet, n_far, n_inside, n_coinc);
		if (n_errors == 0 && pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- circle_circle_intersection.f -----
rtl/cci_pkg.sv
rtl/cci_queue.sv
rtl/cci_front.sv
rtl/cci_delay.sv
rtl/cci_mul.sv
rtl/cci_sqrt.sv
rtl/cci_div.sv
rtl/cci_back.sv
rtl/circle_circle_intersection.sv
rtl/cci_checker.sv
dv/circle_circle_intersection_test.sv
